// File: rtl/core/aff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Affine cipher package
// Shared widths, microcode operations, jump conditions and the control store.
// ----------------------------------------------------------------------------
package aff_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int SW          = SYMBOL_BITS + 2;
    localparam int PW          = 2 * SYMBOL_BITS;
    localparam int QW          = 2 * SYMBOL_BITS + 3;
    localparam int CNT_BITS    = $clog2(2 * SYMBOL_BITS + 1);
    localparam int PC_BITS     = 5;
    localparam int IDX_BITS    = 2;

    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [PC_BITS-1:0]     t_pc;
    typedef logic [IDX_BITS-1:0]    t_idx;

    localparam t_idx REG_MODULUS  = 2'd0;
    localparam t_idx REG_KEY_MULT = 2'd1;
    localparam t_idx REG_KEY_ADD  = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT,
        OP_DIV_EUC,
        OP_DIV_STEP,
        OP_MUL_QS,
        OP_EUC_UPD,
        OP_SET_VALID,
        OP_ENC_MUL,
        OP_DIV_LONG,
        OP_RES_REM,
        OP_INV_NEG,
        OP_INV_HIGH,
        OP_DIV_X,
        OP_SAVE_XM,
        OP_DIV_B,
        OP_DIFF,
        OP_DIFF_FIX,
        OP_DEC_MUL,
        OP_RES_ZERO,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_M_ZERO,
        COND_R2_ZERO,
        COND_DIV_MORE,
        COND_DEC,
        COND_KEY_BAD
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    typedef struct packed {
        logic m_zero;
        logic r2_zero;
        logic div_more;
        logic dec;
        logic key_bad;
    } t_stat;

    localparam t_pc PC_START    = 5'd0;
    localparam t_pc PC_EUC_TOP  = 5'd1;
    localparam t_pc PC_EUC_DIV  = 5'd2;
    localparam t_pc PC_EUC_STEP = 5'd3;
    localparam t_pc PC_EUC_MUL  = 5'd4;
    localparam t_pc PC_EUC_UPD  = 5'd5;
    localparam t_pc PC_EUC_END  = 5'd6;
    localparam t_pc PC_ENC_MUL  = 5'd7;
    localparam t_pc PC_MOD_LOAD = 5'd8;
    localparam t_pc PC_MOD_STEP = 5'd9;
    localparam t_pc PC_MOD_RES  = 5'd10;
    localparam t_pc PC_INV_NEG  = 5'd11;
    localparam t_pc PC_INV_HIGH = 5'd12;
    localparam t_pc PC_XM_LOAD  = 5'd13;
    localparam t_pc PC_XM_STEP  = 5'd14;
    localparam t_pc PC_XM_SAVE  = 5'd15;
    localparam t_pc PC_BM_LOAD  = 5'd16;
    localparam t_pc PC_BM_STEP  = 5'd17;
    localparam t_pc PC_DIFF     = 5'd18;
    localparam t_pc PC_DIFF_FIX = 5'd19;
    localparam t_pc PC_DEC_MUL  = 5'd20;
    localparam t_pc PC_ZERO     = 5'd21;
    localparam t_pc PC_FIN      = 5'd22;

    function automatic t_ctl aff_cw(input t_op op, input t_cond cond, input t_pc target);
        t_ctl w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_ctl aff_rom(input t_pc pc);
        t_ctl w;
        unique case (pc)
            PC_START:    w = aff_cw(OP_INIT,      COND_M_ZERO,   PC_ZERO);
            PC_EUC_TOP:  w = aff_cw(OP_NOP,       COND_R2_ZERO,  PC_EUC_END);
            PC_EUC_DIV:  w = aff_cw(OP_DIV_EUC,   COND_NEXT,     PC_START);
            PC_EUC_STEP: w = aff_cw(OP_DIV_STEP,  COND_DIV_MORE, PC_EUC_STEP);
            PC_EUC_MUL:  w = aff_cw(OP_MUL_QS,    COND_NEXT,     PC_START);
            PC_EUC_UPD:  w = aff_cw(OP_EUC_UPD,   COND_ALWAYS,   PC_EUC_TOP);
            PC_EUC_END:  w = aff_cw(OP_SET_VALID, COND_DEC,      PC_INV_NEG);
            PC_ENC_MUL:  w = aff_cw(OP_ENC_MUL,   COND_NEXT,     PC_START);
            PC_MOD_LOAD: w = aff_cw(OP_DIV_LONG,  COND_NEXT,     PC_START);
            PC_MOD_STEP: w = aff_cw(OP_DIV_STEP,  COND_DIV_MORE, PC_MOD_STEP);
            PC_MOD_RES:  w = aff_cw(OP_RES_REM,   COND_ALWAYS,   PC_FIN);
            PC_INV_NEG:  w = aff_cw(OP_INV_NEG,   COND_KEY_BAD,  PC_ZERO);
            PC_INV_HIGH: w = aff_cw(OP_INV_HIGH,  COND_NEXT,     PC_START);
            PC_XM_LOAD:  w = aff_cw(OP_DIV_X,     COND_NEXT,     PC_START);
            PC_XM_STEP:  w = aff_cw(OP_DIV_STEP,  COND_DIV_MORE, PC_XM_STEP);
            PC_XM_SAVE:  w = aff_cw(OP_SAVE_XM,   COND_NEXT,     PC_START);
            PC_BM_LOAD:  w = aff_cw(OP_DIV_B,     COND_NEXT,     PC_START);
            PC_BM_STEP:  w = aff_cw(OP_DIV_STEP,  COND_DIV_MORE, PC_BM_STEP);
            PC_DIFF:     w = aff_cw(OP_DIFF,      COND_NEXT,     PC_START);
            PC_DIFF_FIX: w = aff_cw(OP_DIFF_FIX,  COND_NEXT,     PC_START);
            PC_DEC_MUL:  w = aff_cw(OP_DEC_MUL,   COND_ALWAYS,   PC_MOD_LOAD);
            PC_ZERO:     w = aff_cw(OP_RES_ZERO,  COND_NEXT,     PC_START);
            PC_FIN:      w = aff_cw(OP_FINISH,    COND_NEXT,     PC_START);
            default:     w = aff_cw(OP_FINISH,    COND_NEXT,     PC_START);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/aff_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Affine cipher datapath
// Working registers, a shared restoring divider, three multipliers and the
// Bezout coefficient update, each operation selected by the microcode.
// ----------------------------------------------------------------------------
module aff_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_load,
    input  wire logic          i_func,
    input  wire aff_pkg::t_sym i_symbol,
    input  wire aff_pkg::t_sym i_modulus,
    input  wire aff_pkg::t_sym i_key_mult,
    input  wire aff_pkg::t_sym i_key_add,
    input  wire aff_pkg::t_op  i_op,
    output aff_pkg::t_stat     o_stat,
    output aff_pkg::t_sym      o_res,
    output logic               o_key_valid
);
    import aff_pkg::*;

    localparam int W = SYMBOL_BITS;

    logic                  r_func;
    logic [W-1:0]          r_x;
    logic [W-1:0]          r_r1;
    logic [W-1:0]          r_r2;
    logic signed [SW-1:0]  r_s1;
    logic signed [SW-1:0]  r_s2;
    logic signed [QW-1:0]  r_qs;
    logic [W-1:0]          r_rem;
    logic [PW-1:0]         r_dq;
    logic [W-1:0]          r_div;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [PW-1:0]         r_prod;
    logic [W-1:0]          r_t;
    logic [W:0]            r_d;
    logic                  r_valid;
    logic [W-1:0]          r_res;

    logic [W:0]            w_trial;
    logic [W:0]            w_sub;
    logic                  w_ge;
    logic signed [W:0]     w_quo;
    logic signed [QW-1:0]  w_snew;
    logic signed [SW-1:0]  w_m_s;

    assign w_trial = {r_rem, r_dq[PW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_quo   = $signed({1'b0, r_dq[W-1:0]});
    assign w_snew  = QW'(r_s1) - r_qs;
    assign w_m_s   = $signed({2'b00, i_modulus});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func <= i_func;
            r_x    <= i_symbol;
        end
        unique case (i_op)
            OP_INIT: begin
                r_r1    <= i_key_mult;
                r_r2    <= i_modulus;
                r_s1    <= SW'(1);
                r_s2    <= '0;
                r_valid <= 1'b0;
            end
            OP_DIV_EUC: begin
                r_dq  <= {r_r1, W'(0)};
                r_div <= r_r2;
                r_rem <= '0;
                r_cnt <= CNT_BITS'(W);
            end
            OP_DIV_X: begin
                r_dq  <= {r_x, W'(0)};
                r_div <= i_modulus;
                r_rem <= '0;
                r_cnt <= CNT_BITS'(W);
            end
            OP_DIV_B: begin
                r_dq  <= {i_key_add, W'(0)};
                r_div <= i_modulus;
                r_rem <= '0;
                r_cnt <= CNT_BITS'(W);
            end
            OP_DIV_LONG: begin
                r_dq  <= r_prod;
                r_div <= i_modulus;
                r_rem <= '0;
                r_cnt <= CNT_BITS'(PW);
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? w_sub[W-1:0] : w_trial[W-1:0];
                r_dq  <= {r_dq[PW-2:0], w_ge};
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            OP_MUL_QS: begin
                r_qs <= QW'(w_quo) * QW'(r_s2);
            end
            OP_EUC_UPD: begin
                r_r1 <= r_r2;
                r_r2 <= r_rem;
                r_s1 <= r_s2;
                r_s2 <= w_snew[SW-1:0];
            end
            OP_SET_VALID: begin
                r_valid <= (r_r1 == W'(1));
            end
            OP_ENC_MUL: begin
                r_prod <= PW'(r_x) * PW'(i_key_mult) + PW'(i_key_add);
            end
            OP_INV_NEG: begin
                if (r_s1 < 0) begin
                    r_s1 <= r_s1 + w_m_s;
                end
            end
            OP_INV_HIGH: begin
                if (r_s1 >= w_m_s) begin
                    r_s1 <= r_s1 - w_m_s;
                end
            end
            OP_SAVE_XM: begin
                r_t <= r_rem;
            end
            OP_DIFF: begin
                r_d <= {1'b0, r_t} + {1'b0, i_modulus} - {1'b0, r_rem};
            end
            OP_DIFF_FIX: begin
                if (r_d >= {1'b0, i_modulus}) begin
                    r_d <= r_d - {1'b0, i_modulus};
                end
            end
            OP_DEC_MUL: begin
                r_prod <= PW'(r_d[W-1:0]) * PW'(r_s1[W-1:0]);
            end
            OP_RES_REM: begin
                r_res <= r_rem;
            end
            OP_RES_ZERO: begin
                r_res <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.m_zero   = (i_modulus == '0);
    assign o_stat.r2_zero  = (r_r2 == '0);
    assign o_stat.div_more = (r_cnt != CNT_BITS'(1));
    assign o_stat.dec      = r_func;
    assign o_stat.key_bad  = ~r_valid;
    assign o_res           = r_res;
    assign o_key_valid     = r_valid;

endmodule
`default_nettype wire

// File: rtl/core/affine_cipher_mod_m.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Affine cipher modulo m
// Encrypts or decrypts one symbol index per item with keys a and b modulo a
// configured alphabet size, using a microcoded sequencer over a small datapath.
//
//   Channel   Direction   Handshake                    Payload
//   input     in          i_in_valid / o_in_stall      i_func, i_symbol_in
//   result    out         o_out_valid / i_out_stall    o_symbol_out, o_key_valid
//   config    in          i_cfg_we                     i_cfg_index, i_cfg_data
//
// Each Euclid iteration runs the shared one-bit-per-cycle divider.
// Reset restores modulus 26, key_mult 1 and key_add 0 and empties the block.
// A new item is accepted while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module affine_cipher_mod_m (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_func,
    input  wire aff_pkg::t_sym i_symbol_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output aff_pkg::t_sym      o_symbol_out,
    output logic               o_key_valid,
    input  wire logic          i_cfg_we,
    input  wire aff_pkg::t_idx i_cfg_index,
    input  wire aff_pkg::t_sym i_cfg_data
);
    import aff_pkg::*;

    t_sym  r_modulus;
    t_sym  r_key_mult;
    t_sym  r_key_add;
    logic  r_busy;
    t_pc   r_pc;
    logic  r_out_valid;
    t_sym  r_symbol_out;
    logic  r_key_valid;

    t_ctl  w_ctl;
    t_op   w_op;
    t_stat w_stat;
    t_sym  w_res;
    logic  w_key_valid;
    logic  w_accept;
    logic  w_take;
    logic  w_finish;
    logic  w_out_free;

    assign w_ctl      = aff_rom(r_pc);
    assign w_op       = r_busy ? w_ctl.op : OP_NOP;
    assign w_accept   = i_in_valid & ~r_busy;
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_finish   = r_busy & (w_ctl.op == OP_FINISH) & w_out_free;

    always_comb begin
        unique case (w_ctl.cond)
            COND_NEXT:     w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_M_ZERO:   w_take = w_stat.m_zero;
            COND_R2_ZERO:  w_take = w_stat.r2_zero;
            COND_DIV_MORE: w_take = w_stat.div_more;
            COND_DEC:      w_take = w_stat.dec;
            COND_KEY_BAD:  w_take = w_stat.key_bad;
            default:       w_take = 1'b0;
        endcase
    end

    aff_dpath u_dpath (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_func      (i_func),
        .i_symbol    (i_symbol_in),
        .i_modulus   (r_modulus),
        .i_key_mult  (r_key_mult),
        .i_key_add   (r_key_add),
        .i_op        (w_op),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_key_valid (w_key_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= SYMBOL_BITS'(26);
            r_key_mult <= SYMBOL_BITS'(1);
            r_key_add  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_KEY_MULT: r_key_mult <= i_cfg_data;
                REG_KEY_ADD:  r_key_add  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pc   <= PC_START;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && w_ctl.op != OP_FINISH) begin
                r_pc <= w_take ? w_ctl.target : r_pc + PC_BITS'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_symbol_out <= w_res;
            r_key_valid  <= w_key_valid;
        end
    end

    assign o_in_stall   = r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_symbol_out = r_symbol_out;
    assign o_key_valid  = r_key_valid;

endmodule
`default_nettype wire
